FILE: src/ucl_pkg.sv
// ----------------------------------------------------------------------------
// ucl_pkg
// Shared types, constants and the keyword step function of the classifier.
// ----------------------------------------------------------------------------
package ucl_pkg;

  localparam int unsigned LineBufferBytesDef = 96;
  localparam int unsigned KwCount            = 5;
  localparam int unsigned KwMaxLen           = 6;
  localparam int unsigned CfgIdxW            = 2;
  localparam int unsigned CfgDataW           = 16;
  localparam logic [15:0] IdleLimitRst       = 16'd120;
  localparam logic [15:0] LinkTimeoutRst     = 16'd10000;

  localparam logic [7:0] ChrNul = 8'h00;
  localparam logic [7:0] ChrLf  = 8'h0a;
  localparam logic [7:0] ChrCr  = 8'h0d;
  localparam logic [7:0] ChrSp  = 8'h20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIdleLimit   = 2'd0,
    CfgLinkTimeout = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    AckStart   = 3'd0,
    AckStop    = 3'd1,
    AckPing    = 3'd2,
    AckStatus  = 3'd3,
    AckUnknown = 3'd4
  } ack_kind_e;

  localparam logic [2:0] StateNameUnknown = 3'd6;
  localparam logic [2:0] StateNameMax     = 3'd5;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdTick = 1'b1
  } cmd_e;

  // keyword table, padded with NUL
  localparam logic [7:0] KwText [KwCount][KwMaxLen] = '{
    '{8'h73, 8'h74, 8'h61, 8'h72, 8'h74, 8'h00},  // start
    '{8'h73, 8'h74, 8'h6f, 8'h70, 8'h00, 8'h00},  // stop
    '{8'h70, 8'h69, 8'h6e, 8'h67, 8'h00, 8'h00},  // ping
    '{8'h68, 8'h65, 8'h6c, 8'h6c, 8'h6f, 8'h00},  // hello
    '{8'h73, 8'h74, 8'h61, 8'h74, 8'h75, 8'h73}   // status
  };
  localparam logic [2:0] KwLen [KwCount] = '{3'd5, 3'd4, 3'd4, 3'd5, 3'd6};
  localparam ack_kind_e KwKind [KwCount] = '{AckStart, AckStop, AckPing, AckPing, AckStatus};

  // classification handed along the cell row, earliest cell wins
  typedef struct packed {
    logic      hit;
    ack_kind_e kind;
  } chain_t;

  typedef struct packed {
    logic      ack_valid;
    ack_kind_e ack_kind;
    logic [2:0] state_name_code;
    logic      link_up;
  } result_t;

  // longest keyword prefix that ends "matched prefix, c"
  function automatic logic [2:0] kw_next(int unsigned w, logic [2:0] p, logic [7:0] c);
    logic [2:0]  pp;
    logic [2:0]  res;
    logic        ok;
    logic        done;
    int unsigned idx;
    pp   = (p >= KwLen[w]) ? 3'd0 : p;
    res  = 3'd0;
    done = 1'b0;
    for (int k = KwMaxLen; k >= 1; k--) begin
      if (!done && (k <= int'(pp) + 1)) begin
        ok = (KwText[w][k-1] == c);
        for (int j = 0; j < KwMaxLen - 1; j++) begin
          if (j + 1 < k) begin
            idx = int'(pp) + 1 - k + j;
            if (KwText[w][j] != KwText[w][idx]) begin
              ok = 1'b0;
            end
          end
        end
        if (ok) begin
          res  = 3'(k);
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

FILE: src/ucl_if.sv
// ----------------------------------------------------------------------------
// ucl_if
// Handshake channels of the classifier: input items, results, config writes.
// ----------------------------------------------------------------------------
interface ucl_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic [2:0] system_state;

  modport source (output valid, command, rx_byte, system_state, input ready);
  modport sink   (input valid, command, rx_byte, system_state, output ready);
endinterface

interface ucl_out_if;
  logic       valid;
  logic       ready;
  logic       ack_valid;
  logic [2:0] ack_kind;
  logic [2:0] state_name_code;
  logic       link_up;

  modport source (output valid, ack_valid, ack_kind, state_name_code, link_up, input ready);
  modport sink   (input valid, ack_valid, ack_kind, state_name_code, link_up, output ready);
endinterface

interface ucl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ucl_pkg::CfgIdxW-1:0]   index;
  logic [ucl_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/uart_command_line_classifier.sv
// ----------------------------------------------------------------------------
// uart_command_line_classifier
// Collects UART bytes into lines and classifies each closed line.
// ----------------------------------------------------------------------------
// The result of an item is registered in the result buffer before it is offered.
// Throughput: one item per cycle unless the result buffer is full;
// a two-entry result buffer keeps intake going while a result waits.
// Reset: asynchronous, active low; clears line state, link flag, idle count,
// and loads idle_limit 120 and link_timeout 10000.
module uart_command_line_classifier #(
  parameter int unsigned LineBufferBytes = ucl_pkg::LineBufferBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ucl_in_if.sink    in_i,
  ucl_cfg_if.sink   cfg_i,
  ucl_out_if.source out_o
);

  localparam int unsigned HeldW = $clog2(LineBufferBytes);
  localparam logic [HeldW-1:0] HeldMax = HeldW'(LineBufferBytes - 1);

  logic [15:0]      idle_limit_q, link_timeout_q;
  logic [HeldW-1:0] held_q, held_d;
  logic             nul_q, nul_d, first_nul_q, first_nul_d, blanks_q, blanks_d;
  logic [15:0]      idle_q, idle_d;
  logic             link_q, link_d;

  logic             accept, buf_full, step, close, clear;
  ucl_pkg::chain_t  chain [ucl_pkg::KwCount+1];
  ucl_pkg::result_t res;
  logic [7:0]       c;

  assign in_i.ready  = !buf_full;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign c           = in_i.rx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q   <= ucl_pkg::IdleLimitRst;
      link_timeout_q <= ucl_pkg::LinkTimeoutRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == ucl_pkg::CfgIdleLimit) begin
        idle_limit_q <= cfg_i.data;
      end else if (cfg_i.index == ucl_pkg::CfgLinkTimeout) begin
        link_timeout_q <= cfg_i.data;
      end
    end
  end

  always_comb begin
    held_d      = held_q;
    nul_d       = nul_q;
    first_nul_d = first_nul_q;
    blanks_d    = blanks_q;
    idle_d      = idle_q;
    link_d      = link_q;
    step        = 1'b0;
    close       = 1'b0;
    if (accept) begin
      if (in_i.command == ucl_pkg::CmdByte) begin
        link_d = 1'b1;
        idle_d = 16'd0;
        if (held_q < HeldMax) begin
          if (held_q == '0 && c == ucl_pkg::ChrNul) begin
            first_nul_d = 1'b1;
          end
          if (c != ucl_pkg::ChrCr && c != ucl_pkg::ChrLf && c != ucl_pkg::ChrSp) begin
            blanks_d = 1'b0;
          end
          if (c == ucl_pkg::ChrNul) begin
            nul_d = 1'b1;
          end
          step   = !nul_d;
          held_d = held_q + 1'b1;
          close  = (c == ucl_pkg::ChrCr) || (c == ucl_pkg::ChrLf);
        end else begin
          close = 1'b1;  // full line, byte dropped
        end
      end else begin
        if (idle_q != 16'hffff) begin
          idle_d = idle_q + 16'd1;
        end
        if (link_q && idle_d > link_timeout_q) begin
          link_d = 1'b0;
        end
        close = (held_q != '0) && (idle_d >= idle_limit_q);
      end
    end
    clear = close;
  end

  // silence uses the flags after this byte; clearing happens in the same edge
  always_comb begin
    res.ack_valid       = close && !first_nul_d && !blanks_d && chain[0].hit == 1'b0;
    res.ack_kind        = ucl_pkg::AckStart;
    res.state_name_code = 3'd0;
    res.link_up         = link_d;
    if (res.ack_valid) begin
      res.ack_kind = chain[ucl_pkg::KwCount].hit ? chain[ucl_pkg::KwCount].kind
                                                  : ucl_pkg::AckUnknown;
      if (res.ack_kind == ucl_pkg::AckStatus) begin
        res.state_name_code = (in_i.system_state <= ucl_pkg::StateNameMax)
                              ? in_i.system_state : ucl_pkg::StateNameUnknown;
      end
    end
  end

  assign chain[0] = '{hit: 1'b0, kind: ucl_pkg::AckUnknown};

  for (genvar g = 0; g < ucl_pkg::KwCount; g++) begin : g_cell
    ucl_kw_cell #(
      .Kw(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .clear_i(clear),
      .byte_i (c),
      .chain_i(chain[g]),
      .chain_o(chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      nul_q       <= 1'b0;
      first_nul_q <= 1'b0;
      blanks_q    <= 1'b1;
      idle_q      <= 16'd0;
      link_q      <= 1'b0;
    end else begin
      idle_q <= idle_d;
      link_q <= link_d;
      if (clear) begin
        held_q      <= '0;
        nul_q       <= 1'b0;
        first_nul_q <= 1'b0;
        blanks_q    <= 1'b1;
      end else begin
        held_q      <= held_d;
        nul_q       <= nul_d;
        first_nul_q <= first_nul_d;
        blanks_q    <= blanks_d;
      end
    end
  end

  ucl_out_buf u_out_buf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(accept),
    .data_i(res),
    .full_o(buf_full),
    .out_o (out_o)
  );

endmodule

FILE: src/ucl_kw_cell.sv
// ----------------------------------------------------------------------------
// ucl_kw_cell
// One keyword matcher cell: prefix progress, found flag, priority hand-on.
// ----------------------------------------------------------------------------
module ucl_kw_cell #(
  parameter int unsigned Kw = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             clear_i,
  input  logic [7:0]       byte_i,
  input  ucl_pkg::chain_t  chain_i,
  output ucl_pkg::chain_t  chain_o
);

  logic [2:0] prog_q, prog_d;
  logic       found_q, found_d;
  logic [2:0] nxt;
  logic       found_now;

  always_comb begin
    nxt       = ucl_pkg::kw_next(Kw, prog_q, byte_i);
    found_now = found_q || (step_i && (nxt >= ucl_pkg::KwLen[Kw]));
    prog_d    = prog_q;
    found_d   = found_now;
    if (step_i) begin
      prog_d = (nxt >= ucl_pkg::KwLen[Kw]) ? 3'd0 : nxt;
    end
    if (clear_i) begin
      prog_d  = 3'd0;
      found_d = 1'b0;
    end
    if (chain_i.hit) begin
      chain_o = chain_i;
    end else if (found_now) begin
      chain_o.hit  = 1'b1;
      chain_o.kind = ucl_pkg::KwKind[Kw];
    end else begin
      chain_o = chain_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q  <= 3'd0;
      found_q <= 1'b0;
    end else begin
      prog_q  <= prog_d;
      found_q <= found_d;
    end
  end

endmodule

FILE: src/ucl_out_buf.sv
// ----------------------------------------------------------------------------
// ucl_out_buf
// Two-entry result buffer, decouples the result sink from item intake.
// ----------------------------------------------------------------------------
module ucl_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ucl_pkg::result_t  data_i,
  output logic              full_o,
  ucl_out_if.source         out_o
);

  logic [1:0]       cnt_q, cnt_d;
  ucl_pkg::result_t e0_q, e1_q;
  logic             pop;

  assign pop    = out_o.valid && out_o.ready;
  assign full_o = (cnt_q == 2'd2);

  assign out_o.valid           = (cnt_q != 2'd0);
  assign out_o.ack_valid       = e0_q.ack_valid;
  assign out_o.ack_kind        = e0_q.ack_kind;
  assign out_o.state_name_code = e0_q.state_name_code;
  assign out_o.link_up         = e0_q.link_up;

  always_comb begin
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
      e0_q <= data_i;
    end else if (pop) begin
      e0_q <= e1_q;
    end
    if (push_i && cnt_q == 2'd1 && !pop) begin
      e1_q <= data_i;
    end
  end

endmodule
